// ----- rtl/assert_macros.svh -----
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define SSTO_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define SSTO_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/ssto_pkg.sv -----
// ----------------------------------------------------------------------------
// ssto_pkg
// Types and constants of the slow stochastic oscillator.
// ----------------------------------------------------------------------------
`default_nettype none

package ssto_pkg;

    localparam int PRICE_W    = 32;
    localparam int PCT_W      = 15;
    localparam int PROD_W     = 47;
    localparam int QUO_W      = 15;
    localparam int BARS_W     = 8;
    localparam int KWIN_W     = 7;
    localparam int DWIN_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [PCT_W-1:0]     PCT_FULL     = 15'd25600;
    localparam logic [PCT_W-1:0]     PCT_HALF     = 15'd12800;
    localparam logic [KWIN_W-1:0]    K_WINDOW_RST = 7'd14;
    localparam logic [DWIN_W-1:0]    D_WINDOW_RST = 5'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_K_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_D_WINDOW = 2'd1;

    typedef struct packed {
        logic [PRICE_W-1:0] high_price;
        logic [PRICE_W-1:0] low_price;
        logic [PRICE_W-1:0] close_price;
    } bar_t;

    typedef struct packed {
        logic [PCT_W-1:0] slow_k;
        logic             slow_k_valid;
        logic [PCT_W-1:0] slow_d;
        logic             slow_d_valid;
    } result_t;

    typedef struct packed {
        logic               start;
        logic [PROD_W-1:0]  dividend;
        logic [PRICE_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HL_SCAN,
        ST_HL_DRAIN,
        ST_RAW_CALC,
        ST_RAW_DIV_GO,
        ST_RAW_DIV_WAIT,
        ST_SM_START,
        ST_SM_SCAN,
        ST_SM_DRAIN,
        ST_K_DIV_GO,
        ST_K_DIV_WAIT,
        ST_D_DIV_GO,
        ST_D_DIV_WAIT,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/ssto_ram.sv -----
// ----------------------------------------------------------------------------
// ssto_ram
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ssto_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/ssto_divider.sv -----
// ----------------------------------------------------------------------------
// ssto_divider
// Restoring divider, one quotient bit per cycle, quotient known to fit.
// ----------------------------------------------------------------------------
`default_nettype none

module ssto_divider (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ssto_pkg::div_req_t req,
    output ssto_pkg::div_rsp_t     rsp
);
    import ssto_pkg::*;

    localparam int CNT_W = $clog2(QUO_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [PROD_W-1:0] rem_reg;
    logic [PROD_W-1:0] dsr_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic              fits;

    assign fits = (rem_reg >= dsr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.dividend;
            dsr_reg <= PROD_W'(req.divisor) << (QUO_W - 1);
            cnt_reg <= CNT_W'(QUO_W - 1);
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - dsr_reg;
            end
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
            dsr_reg <= dsr_reg >> 1;
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

// ----- rtl/slow_stochastic_oscillator.sv -----
// ----------------------------------------------------------------------------
// slow_stochastic_oscillator
// Slow %K and %D over a stream of price bars.
// ----------------------------------------------------------------------------
// One result per bar. While a bar is in work, the high/low window is walked one
// entry a cycle through the read port of the price memory, the smoothing window
// one entry a cycle through the percent memory, and the shared 15-step divider
// runs up to three times (raw %K, slow %K, %D). A new bar is taken as soon as
// the previous result sits in the output register. Configuration writes clear
// the bar count and restart the warm-up; memory contents are kept.
`default_nettype none

module slow_stochastic_oscillator #(
    parameter int MAX_K_WINDOW = 64,
    parameter int MAX_D_WINDOW = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          bar_valid,
    output logic                               bar_ready,
    input  wire ssto_pkg::bar_t                bar,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output ssto_pkg::result_t                  result,
    input  wire logic                          cfg_write,
    input  wire logic [ssto_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ssto_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ssto_pkg::*;

    localparam int KA_W  = $clog2(MAX_K_WINDOW);
    localparam int DA_W  = (MAX_D_WINDOW > 1) ? $clog2(MAX_D_WINDOW) : 1;
    localparam int KJ_W  = $clog2(MAX_K_WINDOW + 1);
    localparam int DJ_W  = $clog2(MAX_D_WINDOW + 1);
    localparam int SUM_W = PCT_W + DJ_W;

    state_t state_reg, state_next;

    logic [KWIN_W-1:0]  k_window_reg;
    logic [DWIN_W-1:0]  d_window_reg;
    logic [BARS_W-1:0]  bars_reg, bars_next;
    logic [KA_W-1:0]    wptr_reg;
    logic [DA_W-1:0]    sptr_reg;
    logic               k_ok_reg, d_ok_reg;
    logic [PRICE_W-1:0] highest_reg, lowest_reg, close_reg, range_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [PCT_W-1:0]   raw_reg, sk_reg, sd_reg;
    logic [SUM_W-1:0]   sum_raw_reg, sum_slow_reg;
    logic [KJ_W-1:0]    hl_j_reg;
    logic [DJ_W-1:0]    sm_j_reg;
    logic               hl_pend_reg, sm_pend_reg;
    logic               result_valid_reg;
    result_t            result_reg;

    logic [31:0]        kw_full, dw_full;
    logic [KJ_W-1:0]    kw;
    logic [DJ_W-1:0]    dw;
    logic               bar_accept, out_free;
    logic [31:0]        hl_addr_sum, hl_addr_wrap, sm_addr_sum, sm_addr_wrap;
    logic [KA_W-1:0]    hl_raddr;
    logic [DA_W-1:0]    sm_raddr;
    logic [2*PRICE_W-1:0] hl_rdata;
    logic [2*PCT_W-1:0] sm_rdata;
    logic               pm_we, hl_scan, sm_scan;
    logic [SUM_W-1:0]   slow_total;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    // effective window lengths
    always_comb
    begin
        if (k_window_reg == '0)
            kw_full = 32'd1;
        else if ({25'd0, k_window_reg} > 32'(MAX_K_WINDOW))
            kw_full = 32'(MAX_K_WINDOW);
        else
            kw_full = {25'd0, k_window_reg};
        if (d_window_reg == '0)
            dw_full = 32'd1;
        else if ({27'd0, d_window_reg} > 32'(MAX_D_WINDOW))
            dw_full = 32'(MAX_D_WINDOW);
        else
            dw_full = {27'd0, d_window_reg};
    end

    assign kw         = kw_full[KJ_W-1:0];
    assign dw         = dw_full[DJ_W-1:0];
    assign bar_accept = bar_valid && bar_ready;
    assign out_free   = !result_valid_reg || result_ready;
    assign bars_next  = (bars_reg == '1) ? bars_reg : bars_reg + BARS_W'(1);
    assign slow_total = sum_slow_reg + SUM_W'(sk_reg);

    // ring addresses walking back from the newest entry
    assign hl_addr_sum  = 32'(wptr_reg) + 32'(MAX_K_WINDOW) - 32'(hl_j_reg);
    assign hl_addr_wrap = (hl_addr_sum >= 32'(MAX_K_WINDOW))
                        ? hl_addr_sum - 32'(MAX_K_WINDOW) : hl_addr_sum;
    assign hl_raddr     = hl_addr_wrap[KA_W-1:0];
    assign sm_addr_sum  = 32'(sptr_reg) + 32'(MAX_D_WINDOW) - 32'(sm_j_reg);
    assign sm_addr_wrap = (sm_addr_sum >= 32'(MAX_D_WINDOW))
                        ? sm_addr_sum - 32'(MAX_D_WINDOW) : sm_addr_sum;
    assign sm_raddr     = sm_addr_wrap[DA_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (bar_accept)
                begin
                    if ({24'd0, bars_next} < kw_full)
                        state_next = ST_SM_START;
                    else if (kw > KJ_W'(1))
                        state_next = ST_HL_SCAN;
                    else
                        state_next = ST_RAW_CALC;
                end
            end
            ST_HL_SCAN:
            begin
                if (hl_j_reg == kw - KJ_W'(1))
                    state_next = ST_HL_DRAIN;
            end
            ST_HL_DRAIN:     state_next = ST_RAW_CALC;
            ST_RAW_CALC:
            begin
                if (highest_reg == lowest_reg || close_reg <= lowest_reg
                    || close_reg >= highest_reg)
                    state_next = ST_SM_START;
                else
                    state_next = ST_RAW_DIV_GO;
            end
            ST_RAW_DIV_GO:   state_next = ST_RAW_DIV_WAIT;
            ST_RAW_DIV_WAIT:
            begin
                if (div_rsp.done)
                    state_next = ST_SM_START;
            end
            ST_SM_START:
            begin
                if (dw > DJ_W'(1))
                    state_next = ST_SM_SCAN;
                else
                    state_next = ST_K_DIV_GO;
            end
            ST_SM_SCAN:
            begin
                if (sm_j_reg == dw - DJ_W'(1))
                    state_next = ST_SM_DRAIN;
            end
            ST_SM_DRAIN:     state_next = ST_K_DIV_GO;
            ST_K_DIV_GO:     state_next = k_ok_reg ? ST_K_DIV_WAIT : ST_D_DIV_GO;
            ST_K_DIV_WAIT:
            begin
                if (div_rsp.done)
                    state_next = ST_D_DIV_GO;
            end
            ST_D_DIV_GO:     state_next = d_ok_reg ? ST_D_DIV_WAIT : ST_FINISH;
            ST_D_DIV_WAIT:
            begin
                if (div_rsp.done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:         state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        bar_ready        = 1'b0;
        hl_scan          = 1'b0;
        sm_scan          = 1'b0;
        pm_we            = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = prod_reg;
        div_req.divisor  = range_reg;
        case (state_reg)
            ST_IDLE:       bar_ready = 1'b1;
            ST_HL_SCAN:    hl_scan = 1'b1;
            ST_SM_SCAN:    sm_scan = 1'b1;
            ST_RAW_DIV_GO: div_req.start = 1'b1;
            ST_K_DIV_GO:
            begin
                div_req.start    = k_ok_reg;
                div_req.dividend = PROD_W'(sum_raw_reg);
                div_req.divisor  = dw_full;
            end
            ST_D_DIV_GO:
            begin
                div_req.start    = d_ok_reg;
                div_req.dividend = PROD_W'(slow_total);
                div_req.divisor  = dw_full;
            end
            ST_FINISH:     pm_we = out_free;
            default:       bar_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            k_window_reg     <= K_WINDOW_RST;
            d_window_reg     <= D_WINDOW_RST;
            bars_reg         <= '0;
            wptr_reg         <= '0;
            sptr_reg         <= '0;
            hl_pend_reg      <= 1'b0;
            sm_pend_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            hl_pend_reg <= hl_scan;
            sm_pend_reg <= sm_scan;
            if (cfg_write && cfg_index == CFG_K_WINDOW)
            begin
                k_window_reg <= cfg_data[KWIN_W-1:0];
                bars_reg     <= '0;
            end
            else if (cfg_write && cfg_index == CFG_D_WINDOW)
            begin
                d_window_reg <= cfg_data[DWIN_W-1:0];
                bars_reg     <= '0;
            end
            else if (bar_accept)
            begin
                bars_reg <= bars_next;
            end
            if (pm_we)
            begin
                wptr_reg <= (wptr_reg == KA_W'(MAX_K_WINDOW - 1))
                          ? '0 : wptr_reg + KA_W'(1);
                sptr_reg <= (sptr_reg == DA_W'(MAX_D_WINDOW - 1))
                          ? '0 : sptr_reg + DA_W'(1);
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (bar_accept)
        begin
            highest_reg <= bar.high_price;
            lowest_reg  <= bar.low_price;
            close_reg   <= bar.close_price;
            raw_reg     <= '0;
            k_ok_reg    <= ({24'd0, bars_next} >= kw_full + dw_full - 32'd1);
            d_ok_reg    <= ({24'd0, bars_next} >= kw_full + 2 * dw_full - 32'd2);
            hl_j_reg    <= KJ_W'(1);
        end
        if (hl_scan)
            hl_j_reg <= hl_j_reg + KJ_W'(1);
        if (hl_pend_reg)
        begin
            if (hl_rdata[2*PRICE_W-1:PRICE_W] > highest_reg)
                highest_reg <= hl_rdata[2*PRICE_W-1:PRICE_W];
            if (hl_rdata[PRICE_W-1:0] < lowest_reg)
                lowest_reg <= hl_rdata[PRICE_W-1:0];
        end
        if (state_reg == ST_RAW_CALC)
        begin
            if (highest_reg == lowest_reg)
                raw_reg <= PCT_HALF;
            else if (close_reg <= lowest_reg)
                raw_reg <= '0;
            else if (close_reg >= highest_reg)
                raw_reg <= PCT_FULL;
            prod_reg  <= PROD_W'(close_reg - lowest_reg) * PROD_W'(PCT_FULL);
            range_reg <= highest_reg - lowest_reg;
        end
        if (state_reg == ST_RAW_DIV_WAIT && div_rsp.done)
            raw_reg <= div_rsp.quotient;
        if (state_reg == ST_SM_START)
        begin
            sum_raw_reg  <= SUM_W'(raw_reg);
            sum_slow_reg <= '0;
            sk_reg       <= '0;
            sd_reg       <= '0;
            sm_j_reg     <= DJ_W'(1);
        end
        if (sm_scan)
            sm_j_reg <= sm_j_reg + DJ_W'(1);
        if (sm_pend_reg)
        begin
            sum_raw_reg  <= sum_raw_reg + SUM_W'(sm_rdata[2*PCT_W-1:PCT_W]);
            sum_slow_reg <= sum_slow_reg + SUM_W'(sm_rdata[PCT_W-1:0]);
        end
        if (state_reg == ST_K_DIV_WAIT && div_rsp.done)
            sk_reg <= div_rsp.quotient;
        if (state_reg == ST_D_DIV_WAIT && div_rsp.done)
            sd_reg <= div_rsp.quotient;
        if (pm_we)
        begin
            result_reg.slow_k       <= sk_reg;
            result_reg.slow_k_valid <= k_ok_reg;
            result_reg.slow_d       <= sd_reg;
            result_reg.slow_d_valid <= d_ok_reg;
        end
    end

    // high/low history, written as the bar is taken
    ssto_ram #(
        .WIDTH  (2 * PRICE_W),
        .DEPTH  (MAX_K_WINDOW),
        .ADDR_W (KA_W)
    ) u_price_ram (
        .clk   (clk),
        .we    (bar_accept),
        .waddr (wptr_reg),
        .wdata ({bar.high_price, bar.low_price}),
        .raddr (hl_raddr),
        .rdata (hl_rdata)
    );

    // raw and slow %K history, written when the bar is finished
    ssto_ram #(
        .WIDTH  (2 * PCT_W),
        .DEPTH  (MAX_D_WINDOW),
        .ADDR_W (DA_W)
    ) u_pct_ram (
        .clk   (clk),
        .we    (pm_we),
        .waddr (sptr_reg),
        .wdata ({raw_reg, sk_reg}),
        .raddr (sm_raddr),
        .rdata (sm_rdata)
    );

    ssto_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

// ----- rtl/ssto_checker.sv -----
// ----------------------------------------------------------------------------
// ssto_checker
// Port-level checks on the slow stochastic oscillator.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ssto_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              bar_valid,
    input wire logic              bar_ready,
    input wire logic              result_valid,
    input wire logic              result_ready,
    input wire ssto_pkg::result_t result
);
    import ssto_pkg::*;

    `SSTO_ASSERT(a_result_hold, clk, rst_n, result_valid && !result_ready |=> result_valid && $stable(result), "result beat changed while stalled")
    `SSTO_ASSERT(a_one_bar_at_a_time, clk, rst_n, bar_valid && bar_ready |=> !bar_ready, "bar taken while one is in work")
    `SSTO_ASSERT(a_k_zero_in_warmup, clk, rst_n, result_valid && !result.slow_k_valid |-> result.slow_k == '0 && !result.slow_d_valid && result.slow_d == '0, "warm-up result not zero")
    `SSTO_ASSERT(a_pct_range, clk, rst_n, result_valid |-> result.slow_k <= PCT_FULL && result.slow_d <= PCT_FULL, "percent out of range")
    `SSTO_ASSERT_ALWAYS(a_no_result_in_reset, clk, !rst_n |-> !result_valid, "result beat during reset")

endmodule

bind slow_stochastic_oscillator ssto_checker u_ssto_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .bar_valid    (bar_valid),
    .bar_ready    (bar_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire
